[hw/rtl/mhr_pkg.sv]
// Shared types and constants for the module header recognizer.
package mhr_pkg;

  typedef enum logic [5:0] {
    PH_START       = 6'b000001,
    PH_KEYWORD     = 6'b000010,
    PH_EXPECT_NAME = 6'b000100,
    PH_IN_NAME     = 6'b001000,
    PH_DOT_OR_END  = 6'b010000,
    PH_DONE        = 6'b100000
  } phase_t;

  typedef enum logic [2:0] {
    CM_NONE  = 3'b001,
    CM_LINE  = 3'b010,
    CM_BLOCK = 3'b100
  } cmode_t;

  typedef enum logic [2:0] {
    PL_NONE  = 3'b001,
    PL_SLASH = 3'b010,
    PL_STAR  = 3'b100
  } look_t;

  localparam logic [2:0] V_OK          = 3'd0;
  localparam logic [2:0] V_BAD_DIR     = 3'd1;
  localparam logic [2:0] V_BAD_DOT     = 3'd2;
  localparam logic [2:0] V_MISSING_SEMI = 3'd3;
  localparam logic [2:0] V_NO_HEADER   = 3'd4;
  localparam logic [2:0] V_EXTRA_IDENT = 3'd5;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam int unsigned KW_LEN = 6;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] kw_cnt;
    logic       kw_ok;
    cmode_t     cmode;
    look_t      look;
  } state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] name_char;
    logic [2:0] verdict;
    logic       last;
  } result_t;

  // "module", one letter per position
  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h6D;
      3'd1:    c = 8'h6F;
      3'd2:    c = 8'h64;
      3'd3:    c = 8'h75;
      3'd4:    c = 8'h6C;
      3'd5:    c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'd32) || (b == 8'd9) || (b == 8'd13) || (b == 8'd10) ||
           (b == 8'd11) || (b == 8'd12);
  endfunction

  function automatic logic is_ident_start(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || (b == 8'h5F);
  endfunction

  function automatic logic is_ident_part(input logic [7:0] b);
    return is_ident_start(b) || (b >= 8'h30 && b <= 8'h39);
  endfunction

endpackage

[hw/rtl/mhr_step.sv]
// Per-byte next-state and result logic of the header recognizer.
module mhr_step (
  input  mhr_pkg::state_t  cur,
  input  logic [7:0]       in_byte,
  input  logic             end_of_input,
  output mhr_pkg::state_t  nxt,
  output logic             res_valid,
  output mhr_pkg::result_t res
);

  always_comb begin
    mhr_pkg::phase_t ph;
    logic            go_on;
    logic            matched;
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    ph        = cur.phase;
    go_on     = 1'b0;
    matched   = cur.kw_ok && (cur.kw_cnt == 3'(mhr_pkg::KW_LEN));

    if (end_of_input) begin
      if (cur.phase != mhr_pkg::PH_DONE) begin
        res_valid   = 1'b1;
        res.kind    = 1'b1;
        res.last    = 1'b1;
        res.verdict = mhr_pkg::V_NO_HEADER;
        if (cur.cmode == mhr_pkg::CM_NONE && cur.look == mhr_pkg::PL_SLASH) begin
          res.verdict = mhr_pkg::V_BAD_DIR;
        end else if (cur.phase == mhr_pkg::PH_KEYWORD && !matched) begin
          res.verdict = mhr_pkg::V_BAD_DIR;
        end
      end
      // rearm
      nxt.phase  = mhr_pkg::PH_START;
      nxt.kw_cnt = 3'd0;
      nxt.kw_ok  = 1'b1;
      nxt.cmode  = mhr_pkg::CM_NONE;
      nxt.look   = mhr_pkg::PL_NONE;
    end else if (cur.phase == mhr_pkg::PH_DONE) begin
      nxt = cur;
    end else if (cur.cmode == mhr_pkg::CM_BLOCK) begin
      if (cur.look == mhr_pkg::PL_STAR && in_byte == mhr_pkg::CH_SLASH) begin
        nxt.cmode = mhr_pkg::CM_NONE;
        nxt.look  = mhr_pkg::PL_NONE;
      end else begin
        nxt.look = (in_byte == mhr_pkg::CH_STAR) ? mhr_pkg::PL_STAR : mhr_pkg::PL_NONE;
      end
    end else if (cur.cmode == mhr_pkg::CM_LINE) begin
      if (in_byte == mhr_pkg::CH_LF) begin
        nxt.cmode = mhr_pkg::CM_NONE;
      end
    end else if (cur.look == mhr_pkg::PL_SLASH) begin
      nxt.look = mhr_pkg::PL_NONE;
      if (in_byte == mhr_pkg::CH_SLASH) begin
        nxt.cmode = mhr_pkg::CM_LINE;
      end else if (in_byte == mhr_pkg::CH_STAR) begin
        nxt.cmode = mhr_pkg::CM_BLOCK;
      end else begin
        res_valid   = 1'b1;
        res.kind    = 1'b1;
        res.last    = 1'b1;
        res.verdict = mhr_pkg::V_BAD_DIR;
      end
    end else begin
      go_on = 1'b1;
      if (cur.phase == mhr_pkg::PH_KEYWORD) begin
        if (mhr_pkg::is_ident_part(in_byte)) begin
          if (cur.kw_cnt >= 3'(mhr_pkg::KW_LEN) ||
              in_byte != mhr_pkg::kw_char(cur.kw_cnt)) begin
            nxt.kw_ok = 1'b0;
          end
          if (cur.kw_cnt != 3'd7) begin
            nxt.kw_cnt = cur.kw_cnt + 3'd1;
          end
          go_on = 1'b0;
        end else if (!matched) begin
          res_valid   = 1'b1;
          res.kind    = 1'b1;
          res.last    = 1'b1;
          res.verdict = mhr_pkg::V_BAD_DIR;
          go_on       = 1'b0;
        end else begin
          ph = mhr_pkg::PH_EXPECT_NAME;
        end
      end else if (cur.phase == mhr_pkg::PH_IN_NAME) begin
        if (mhr_pkg::is_ident_part(in_byte)) begin
          res_valid     = 1'b1;
          res.name_char = in_byte;
          go_on         = 1'b0;
        end else begin
          ph = mhr_pkg::PH_DOT_OR_END;
        end
      end

      if (go_on) begin
        nxt.phase = ph;
        if (mhr_pkg::is_space(in_byte)) begin
          nxt.phase = ph;
        end else if (in_byte == mhr_pkg::CH_SLASH) begin
          nxt.look = mhr_pkg::PL_SLASH;
        end else if (mhr_pkg::is_ident_start(in_byte)) begin
          if (ph == mhr_pkg::PH_START) begin
            nxt.phase  = mhr_pkg::PH_KEYWORD;
            nxt.kw_cnt = 3'd1;
            nxt.kw_ok  = (in_byte == mhr_pkg::kw_char(3'd0));
          end else if (ph == mhr_pkg::PH_EXPECT_NAME) begin
            nxt.phase     = mhr_pkg::PH_IN_NAME;
            res_valid     = 1'b1;
            res.name_char = in_byte;
          end else begin
            res_valid   = 1'b1;
            res.kind    = 1'b1;
            res.last    = 1'b1;
            res.verdict = mhr_pkg::V_EXTRA_IDENT;
          end
        end else if (in_byte == mhr_pkg::CH_DOT) begin
          if (ph != mhr_pkg::PH_DOT_OR_END) begin
            res_valid   = 1'b1;
            res.kind    = 1'b1;
            res.last    = 1'b1;
            res.verdict = mhr_pkg::V_BAD_DOT;
          end else begin
            nxt.phase     = mhr_pkg::PH_EXPECT_NAME;
            res_valid     = 1'b1;
            res.name_char = in_byte;
          end
        end else if (in_byte == mhr_pkg::CH_SEMI) begin
          res_valid   = 1'b1;
          res.kind    = 1'b1;
          res.last    = 1'b1;
          res.verdict = (ph == mhr_pkg::PH_DOT_OR_END) ? mhr_pkg::V_OK
                                                       : mhr_pkg::V_MISSING_SEMI;
        end else begin
          res_valid   = 1'b1;
          res.kind    = 1'b1;
          res.last    = 1'b1;
          res.verdict = mhr_pkg::V_BAD_DIR;
        end
      end
    end

    // any verdict closes the parse (rearm above takes priority)
    if (res_valid && res.kind && !end_of_input) begin
      nxt.phase = mhr_pkg::PH_DONE;
    end
  end

endmodule

[hw/rtl/mhr_obuf.sv]
// Output register with one skid entry for the result channel.
module mhr_obuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mhr_pkg::result_t push_data,
  output logic             can_accept,
  output logic             out_valid,
  output mhr_pkg::result_t out_data,
  input  logic             out_ready
);

  logic             main_v_r, main_v_nxt;
  logic             skid_v_r, skid_v_nxt;
  mhr_pkg::result_t main_r, main_nxt;
  mhr_pkg::result_t skid_r, skid_nxt;

  assign can_accept = !skid_v_r;
  assign out_valid  = main_v_r;
  assign out_data   = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (!main_v_r || out_ready) begin
      if (skid_v_r) begin
        main_v_nxt = 1'b1;
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = push;
        main_nxt   = push_data;
      end
    end else if (push) begin
      // main beat stalled: park the new one
      skid_v_nxt = 1'b1;
      skid_nxt   = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

[hw/rtl/module_header_recognizer_core.sv]
// Top level of the module header recognizer: parse state, step logic, output buffer.
//
//  channel | direction | tdata                       | tuser        | tlast
//  in_     | slave     | [7:0] in_byte               | -            | end_of_input
//  out_    | master    | [7:0] name_char [10:8] verd | result_kind  | last
//
// One input beat per cycle while in_tready is high; each beat updates the parse state in the
// cycle it is accepted, and its result, if any, reaches out_ through the output register.
// A two-entry output buffer (register plus skid) sets the stall behavior: in_tready
// drops only while both entries hold results that out_ has not taken.
// rst_n (synchronous, active low) returns the parser to awaiting the keyword and
// empties the output buffer.
module module_header_recognizer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] name_char, [10:8] verdict, [15:11] zero
  output logic        out_tuser,  // result_kind
  output logic        out_tlast   // last
);

  mhr_pkg::state_t  state_r;
  mhr_pkg::state_t  state_nxt;
  mhr_pkg::result_t step_res;
  mhr_pkg::result_t out_res;
  logic             step_valid;
  logic             can_accept;
  logic             in_beat;

  assign in_tready = can_accept;
  assign in_beat   = in_tvalid && can_accept;

  mhr_step u_step (
    .cur          (state_r),
    .in_byte      (in_tdata),
    .end_of_input (in_tlast),
    .nxt          (state_nxt),
    .res_valid    (step_valid),
    .res          (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase  <= mhr_pkg::PH_START;
      state_r.kw_cnt <= 3'd0;
      state_r.kw_ok  <= 1'b1;
      state_r.cmode  <= mhr_pkg::CM_NONE;
      state_r.look   <= mhr_pkg::PL_NONE;
    end else if (in_beat) begin
      state_r <= state_nxt;
    end
  end

  mhr_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_beat && step_valid),
    .push_data  (step_res),
    .can_accept (can_accept),
    .out_valid  (out_tvalid),
    .out_data   (out_res),
    .out_ready  (out_tready)
  );

  assign out_tdata = {5'b0, out_res.verdict, out_res.name_char};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

[test/tb_module_header_recognizer_core.sv]
// Testbench for module_header_recognizer_core: directed and random source texts.
`timescale 1ns / 100ps

module tb_module_header_recognizer_core;

  localparam int unsigned QUIET_LIMIT  = 1000;
  localparam logic [47:0] KEYWORD_TEXT = "module";
  localparam logic        KIND_NAME    = 1'b0;
  localparam logic        KIND_VERDICT = 1'b1;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  // parser model state
  mhr_pkg::phase_t txt_phase;
  logic [2:0]      kw_seen;
  logic            kw_good;
  mhr_pkg::cmode_t cmt_mode;
  mhr_pkg::look_t  held_byte;

  mhr_pkg::result_t header_results[$];
  logic [7:0]  text_buf[$];
  int unsigned mismatches   = 0;
  int unsigned live_beats   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left   = 0;
  bit          idle_on      = 1'b1;

  module_header_recognizer_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- parser model ----------------

  function automatic logic space_byte(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A) ||
           (b == 8'h0B) || (b == 8'h0C);
  endfunction

  function automatic logic ident_first(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || (b == 8'h5F);
  endfunction

  function automatic logic ident_char(input logic [7:0] b);
    return ident_first(b) || (b >= 8'h30 && b <= 8'h39);
  endfunction

  function void parser_clear();
    txt_phase = mhr_pkg::PH_START;
    kw_seen   = 3'd0;
    kw_good   = 1'b1;
    cmt_mode  = mhr_pkg::CM_NONE;
    held_byte = mhr_pkg::PL_NONE;
  endfunction

  function void push_name(input logic [7:0] b);
    mhr_pkg::result_t r;
    r.kind      = KIND_NAME;
    r.name_char = b;
    r.verdict   = mhr_pkg::V_OK;
    r.last      = 1'b0;
    header_results.push_back(r);
  endfunction

  function void push_verdict(input logic [2:0] v);
    mhr_pkg::result_t r;
    r.kind      = KIND_VERDICT;
    r.name_char = 8'h00;
    r.verdict   = v;
    r.last      = 1'b1;
    header_results.push_back(r);
    txt_phase = mhr_pkg::PH_DONE;
  endfunction

  function logic keyword_complete();
    return kw_good && (kw_seen == 3'd6);
  endfunction

  // count saturates at 7 so an overlong word never matches
  function void keyword_take(input logic [7:0] b);
    if (kw_seen >= 3'd6)
      kw_good = 1'b0;
    else if (b != KEYWORD_TEXT[8*(5-kw_seen) +: 8])
      kw_good = 1'b0;
    if (kw_seen < 3'd7)
      kw_seen = kw_seen + 3'd1;
  endfunction

  function void predict_beat(input logic [7:0] b, input logic eoi);
    logic [2:0] v;
    if (eoi) begin
      if (txt_phase != mhr_pkg::PH_DONE) begin
        v = mhr_pkg::V_NO_HEADER;
        if (cmt_mode == mhr_pkg::CM_NONE && held_byte == mhr_pkg::PL_SLASH)
          v = mhr_pkg::V_BAD_DIR;
        else if (txt_phase == mhr_pkg::PH_KEYWORD && !keyword_complete())
          v = mhr_pkg::V_BAD_DIR;
        push_verdict(v);
      end
      parser_clear();
      return;
    end
    if (txt_phase == mhr_pkg::PH_DONE)
      return;
    if (cmt_mode == mhr_pkg::CM_BLOCK) begin
      if (held_byte == mhr_pkg::PL_STAR && b == mhr_pkg::CH_SLASH) begin
        cmt_mode  = mhr_pkg::CM_NONE;
        held_byte = mhr_pkg::PL_NONE;
      end else if (b == mhr_pkg::CH_STAR) begin
        held_byte = mhr_pkg::PL_STAR;
      end else begin
        held_byte = mhr_pkg::PL_NONE;
      end
      return;
    end
    if (cmt_mode == mhr_pkg::CM_LINE) begin
      if (b == mhr_pkg::CH_LF)
        cmt_mode = mhr_pkg::CM_NONE;
      return;
    end
    if (held_byte == mhr_pkg::PL_SLASH) begin
      held_byte = mhr_pkg::PL_NONE;
      if (b == mhr_pkg::CH_SLASH)
        cmt_mode = mhr_pkg::CM_LINE;
      else if (b == mhr_pkg::CH_STAR)
        cmt_mode = mhr_pkg::CM_BLOCK;
      else
        push_verdict(mhr_pkg::V_BAD_DIR);
      return;
    end
    if (txt_phase == mhr_pkg::PH_KEYWORD) begin
      if (ident_char(b)) begin
        keyword_take(b);
        return;
      end
      if (!keyword_complete()) begin
        push_verdict(mhr_pkg::V_BAD_DIR);
        return;
      end
      txt_phase = mhr_pkg::PH_EXPECT_NAME;
    end else if (txt_phase == mhr_pkg::PH_IN_NAME) begin
      if (ident_char(b)) begin
        push_name(b);
        return;
      end
      txt_phase = mhr_pkg::PH_DOT_OR_END;
    end
    if (space_byte(b))
      return;
    if (b == mhr_pkg::CH_SLASH) begin
      held_byte = mhr_pkg::PL_SLASH;
      return;
    end
    if (ident_first(b)) begin
      if (txt_phase == mhr_pkg::PH_START) begin
        txt_phase = mhr_pkg::PH_KEYWORD;
        kw_seen   = 3'd0;
        kw_good   = 1'b1;
        keyword_take(b);
      end else if (txt_phase == mhr_pkg::PH_EXPECT_NAME) begin
        txt_phase = mhr_pkg::PH_IN_NAME;
        push_name(b);
      end else begin
        push_verdict(mhr_pkg::V_EXTRA_IDENT);
      end
      return;
    end
    if (b == mhr_pkg::CH_DOT) begin
      if (txt_phase != mhr_pkg::PH_DOT_OR_END) begin
        push_verdict(mhr_pkg::V_BAD_DOT);
      end else begin
        txt_phase = mhr_pkg::PH_EXPECT_NAME;
        push_name(b);
      end
      return;
    end
    if (b == mhr_pkg::CH_SEMI) begin
      push_verdict((txt_phase == mhr_pkg::PH_DOT_OR_END) ? mhr_pkg::V_OK
                                                         : mhr_pkg::V_MISSING_SEMI);
      return;
    end
    push_verdict(mhr_pkg::V_BAD_DIR);
  endfunction

  // ---------------- text generation ----------------

  function automatic logic [7:0] rand_first();
    case ($urandom_range(0, 4))
      0, 1:    return 8'h41 + 8'($urandom_range(0, 25));
      2, 3:    return 8'h61 + 8'($urandom_range(0, 25));
      default: return 8'h5F;
    endcase
  endfunction

  function automatic logic [7:0] rand_part();
    if ($urandom_range(0, 3) == 0)
      return 8'h30 + 8'($urandom_range(0, 9));
    return rand_first();
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 5))
      0:       return 8'h09;
      1:       return 8'h0A;
      2:       return 8'h0B;
      3:       return 8'h0C;
      4:       return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  // biased toward bytes the parser reacts to
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: return rand_part();
      6, 7:             return rand_space();
      8, 9:             return mhr_pkg::CH_SLASH;
      10, 11:           return mhr_pkg::CH_STAR;
      12:               return mhr_pkg::CH_DOT;
      13:               return mhr_pkg::CH_SEMI;
      14:               return mhr_pkg::CH_LF;
      default:          return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function void add_string(input string s);
    for (int i = 0; i < s.len(); i++)
      text_buf.push_back(s[i]);
  endfunction

  function void add_ident(input int unsigned len);
    text_buf.push_back(rand_first());
    repeat (len - 1) text_buf.push_back(rand_part());
  endfunction

  function void add_keyword(input int unsigned len);
    for (int i = 0; i < len; i++)
      text_buf.push_back(KEYWORD_TEXT[8*(5-i) +: 8]);
  endfunction

  function void add_filler();
    logic [7:0] c;
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5, 6: text_buf.push_back(rand_space());
      7, 8, 9: begin
        add_string("//");
        repeat ($urandom_range(0, 6)) begin
          c = 8'($urandom_range(0, 255));
          if (c == mhr_pkg::CH_LF)
            c = 8'h20;
          text_buf.push_back(c);
        end
        text_buf.push_back(mhr_pkg::CH_LF);
      end
      10, 11, 12, 13, 14: begin
        add_string("/*");
        repeat ($urandom_range(0, 6))
          text_buf.push_back(($urandom_range(0, 3) == 0) ? mhr_pkg::CH_STAR
                                                         : 8'($urandom_range(0, 255)));
        add_string("*/");
      end
      default: begin
        // lone slash
        text_buf.push_back(mhr_pkg::CH_SLASH);
        text_buf.push_back(noise_byte());
      end
    endcase
  endfunction

  function void build_header();
    int unsigned parts;
    text_buf.delete();
    repeat ($urandom_range(0, 2)) add_filler();
    case ($urandom_range(0, 11))
      9:  add_keyword($urandom_range(1, 5));
      10: begin
        add_keyword(6);
        text_buf.push_back(rand_part());
      end
      11: add_ident($urandom_range(1, 8));
      default: add_keyword(6);
    endcase
    add_filler();
    repeat ($urandom_range(0, 1)) add_filler();
    parts = $urandom_range(1, 4);
    for (int i = 0; i < parts; i++) begin
      add_ident($urandom_range(1, 6));
      if (i + 1 < parts) begin
        if ($urandom_range(0, 4) == 0)
          add_filler();
        text_buf.push_back(mhr_pkg::CH_DOT);
        if ($urandom_range(0, 4) == 0)
          add_filler();
      end
    end
    if ($urandom_range(0, 3) == 0)
      add_filler();
    case ($urandom_range(0, 9))
      7:       text_buf.push_back(noise_byte());
      8:       text_buf.push_back(mhr_pkg::CH_DOT);
      9:       ;
      default: text_buf.push_back(mhr_pkg::CH_SEMI);
    endcase
    // bytes past the verdict are dropped by the block
    repeat ($urandom_range(0, 3)) text_buf.push_back(noise_byte());
    if ($urandom_range(0, 7) == 0)
      text_buf = text_buf[0:$urandom_range(0, text_buf.size() - 1)];
  endfunction

  function void build_noise();
    text_buf.delete();
    repeat ($urandom_range(1, 12)) text_buf.push_back(noise_byte());
  endfunction

  // ---------------- driving ----------------

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(input logic [7:0] b, input logic eoi);
    if (idle_on && $urandom_range(0, 15) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eoi;
    do @(posedge clk); while (!in_tready);
    live_beats++;
    predict_beat(b, eoi);
    @(negedge clk);
  endtask

  task automatic send_source_text();
    foreach (text_buf[i])
      send_beat(text_buf[i], 1'b0);
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic run_case(input string s);
    text_buf.delete();
    add_string(s);
    send_source_text();
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (header_results.size() != 0) @(negedge clk);
  endtask

  // ---------------- tests ----------------

  task automatic test_directed();
    run_case("module a.b_1.Z9;tail");
    run_case("");
    run_case("module");
    run_case("mod");
    run_case("modules x;");
    run_case("Module x;");
    run_case("module\tq.r ;");
    run_case("// line\n/* a *\n/ b **/ module/**/z;");
    run_case("module\r\nUa_/*x*/.b;");
    run_case("/x");
    run_case("/");
    run_case("/* open");
    run_case("module a/");
    run_case("module a b");
    run_case("module .a");
    run_case("module a..b");
    run_case("module ;");
    run_case("module a.;");
    run_case("module a+");
    // byte extremes inside a comment and as a name terminator
    text_buf.delete();
    add_string("/*");
    text_buf.push_back(8'h00);
    text_buf.push_back(8'hFF);
    add_string("*/module b");
    text_buf.push_back(8'h00);
    send_source_text();
    text_buf.delete();
    add_string("module a");
    text_buf.push_back(8'hFF);
    send_source_text();
  endtask

  task automatic test_random_text(input int unsigned beat_target);
    while (live_beats < beat_target) begin
      if ($urandom_range(0, 6) == 0)
        build_noise();
      else
        build_header();
      send_source_text();
    end
  endtask

  task automatic test_sender_pause();
    repeat (3) begin
      build_header();
      send_source_text();
    end
    hold_until_drained();
  endtask

  // ---------------- result checking ----------------

  always @(posedge clk) begin
    mhr_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (header_results.size() == 0) begin
        $error("unexpected result beat: tuser %0d tdata %04h tlast %0d",
               out_tuser, out_tdata, out_tlast);
        mismatches++;
      end else begin
        want = header_results.pop_front();
        if (out_tuser !== want.kind) begin
          $error("result_kind mismatch: expected %0d, actual %0d", want.kind, out_tuser);
          mismatches++;
        end
        if (out_tdata[7:0] !== want.name_char) begin
          $error("name_char mismatch: expected %02h, actual %02h",
                 want.name_char, out_tdata[7:0]);
          mismatches++;
        end
        if (out_tdata[10:8] !== want.verdict) begin
          $error("verdict mismatch: expected %0d, actual %0d", want.verdict, out_tdata[10:8]);
          mismatches++;
        end
        if (out_tdata[15:11] !== 5'd0) begin
          $error("tdata pad mismatch: expected 0, actual %02h", out_tdata[15:11]);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // result-side backpressure in bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("module_header_recognizer_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    parser_clear();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_text(500);
    test_sender_pause();
    test_random_text(1000);
    idle_on = 1'b0;
    test_random_text(1200);

    hold_until_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("module_header_recognizer_core test passed");
    else
      $display("module_header_recognizer_core test failed");
    $finish;
  end

endmodule
